/* design/sat_shape_overlap_test_core_macros.svh */
// Assertion helpers for the overlap test core.
`ifndef SAT_SHAPE_OVERLAP_TEST_CORE_MACROS_SVH
`define SAT_SHAPE_OVERLAP_TEST_CORE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sat core: property violated");

// Condition that must never be seen out of reset.
`define SAT_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("sat core: forbidden condition seen");

`endif

/* design/sat_pkg.sv */
package sat_pkg;

  // shape kind codes; the unused code reads as absent
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_RECT   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    PAIR_NONE,
    PAIR_CC,
    PAIR_RR,
    PAIR_RC
  } pair_e;

  // pipeline depths
  localparam int TRIG_LAT = 24;
  localparam int GEOM_LAT = 8;

  // fraction bits of the unit vectors
  function automatic int trig_frac(input int cw);
    return ((60 - cw) < 30) ? (60 - cw) : 30;
  endfunction

endpackage

/* design/sat_series_step.sv */
// One Horner step t' = 1 - ((x2*t)>>30)/K, clamped at 0, in three stages.
module sat_series_step #(
  parameter int K = 2
) (
  input  logic        clk_i,
  input  logic [31:0] x2_i,
  input  logic [30:0] t_i,
  output logic [30:0] t_o
);

  localparam int          K2    = K / 2;
  localparam logic [34:0] RECIP = 35'((64'd1 << 34) / K2);
  localparam logic [31:0] ONE   = 32'd1 << 30;

  logic [31:0] p_q;
  logic [30:0] h_q;
  logic [30:0] qe_q;
  logic [30:0] t_q;
  logic [37:0] rem;
  logic [31:0] quo;

  // K is even: floor(p/K) == floor((p>>1)/(K/2))
  always_comb begin
    rem = 38'(h_q) - 38'(qe_q) * 38'(K2);
    quo = 32'(qe_q) + ((rem >= 38'(K2)) ? 32'd1 : 32'd0);
  end

  always_ff @(posedge clk_i) begin
    p_q  <= 32'((63'(x2_i) * 63'(t_i)) >> 30);
    h_q  <= p_q[31:1];
    qe_q <= 31'((66'(p_q[31:1]) * 66'(RECIP)) >> 34);
    t_q  <= (quo > ONE) ? '0 : 31'(ONE - quo);
  end

  assign t_o = t_q;

endmodule

/* design/sat_trig.sv */
// Angle to unit vector (cos, sin) through a register pipeline.
module sat_trig #(
  parameter int CW = 32,
  parameter int AW = 16
) (
  input  logic                                    clk_i,
  input  logic [AW-1:0]                           angle_i,
  output logic signed [sat_pkg::trig_frac(CW)+1:0] ux_o,
  output logic signed [sat_pkg::trig_frac(CW)+1:0] uy_o
);

  localparam int          F       = sat_pkg::trig_frac(CW);
  localparam int          SH      = 30 - F;
  localparam int          RSH     = (SH > 0) ? SH - 1 : 0;
  localparam int          SDL     = 22;
  localparam logic [30:0] ONE     = 31'd1 << 30;
  localparam logic [30:0] HALF_PI = 31'd1686629713;
  localparam int          SIN_K [6] = '{156, 110, 72, 42, 20, 6};
  localparam int          COS_K [7] = '{182, 132, 90, 56, 30, 12, 2};

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_e;

  typedef struct packed {
    quad_e       quad;
    logic [30:0] x;
    logic [31:0] x2;
  } side_t;

  logic [29:0]        q;
  quad_e              quad1_q;
  logic [30:0]        x1_q;
  side_t              sd_q [SDL];
  logic [30:0]        ts [7];
  logic [30:0]        tc [8];
  logic [31:0]        s_q, s1_q, s2_q;
  logic [30:0]        s_cl;
  logic [F:0]         sf, cf;
  logic signed [F+1:0] cs, ss, ux_q, uy_q;

  function automatic logic [F:0] to_frac(input logic [30:0] v);
    if (SH == 0) return (F+1)'(v);
    return (F+1)'((32'(v) + (32'd1 << RSH)) >> SH);
  endfunction

  assign q = 30'(angle_i[AW-3:0]) << (32 - AW);

  always_ff @(posedge clk_i) begin
    quad1_q     <= quad_e'(angle_i[AW-1:AW-2]);
    x1_q        <= 31'((61'(q) * 61'(HALF_PI)) >> 30);
    sd_q[0].quad <= quad1_q;
    sd_q[0].x    <= x1_q;
    sd_q[0].x2   <= 32'((62'(x1_q) * 62'(x1_q)) >> 30);
    for (int i = 1; i < SDL; i++) sd_q[i] <= sd_q[i-1];
  end

  assign ts[0] = ONE;
  assign tc[0] = ONE;

  for (genvar j = 0; j < 6; j++) begin : g_step
    sat_series_step #(.K(SIN_K[j])) u_sin (
      .clk_i (clk_i),
      .x2_i  (sd_q[3*j].x2),
      .t_i   (ts[j]),
      .t_o   (ts[j+1])
    );
    sat_series_step #(.K(COS_K[j])) u_cos (
      .clk_i (clk_i),
      .x2_i  (sd_q[3*j].x2),
      .t_i   (tc[j]),
      .t_o   (tc[j+1])
    );
  end

  sat_series_step #(.K(COS_K[6])) u_cos_last (
    .clk_i (clk_i),
    .x2_i  (sd_q[18].x2),
    .t_i   (tc[6]),
    .t_o   (tc[7])
  );

  // sin = x * series, lined up with the last cos step
  always_ff @(posedge clk_i) begin
    s_q  <= 32'((62'(sd_q[18].x) * 62'(ts[6])) >> 30);
    s1_q <= s_q;
    s2_q <= s1_q;
  end

  always_comb begin
    s_cl = (s2_q > 32'(ONE)) ? ONE : s2_q[30:0];
    sf   = to_frac(s_cl);
    cf   = to_frac(tc[7]);
    cs   = $signed({1'b0, cf});
    ss   = $signed({1'b0, sf});
  end

  always_ff @(posedge clk_i) begin
    unique case (sd_q[SDL-1].quad)
      QUAD_I:   begin ux_q <= cs;  uy_q <= ss;  end
      QUAD_II:  begin ux_q <= -ss; uy_q <= cs;  end
      QUAD_III: begin ux_q <= -cs; uy_q <= -ss; end
      QUAD_IV:  begin ux_q <= ss;  uy_q <= -cs; end
      default:  begin ux_q <= cs;  uy_q <= ss;  end
    endcase
  end

  assign ux_o = ux_q;
  assign uy_o = uy_q;

endmodule

/* design/sat_mul.sv */
// Unsigned W x W multiply from four half-width partial products, two stages.
module sat_mul #(
  parameter int W = 64
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  localparam int LO = W / 2;
  localparam int HI = W - LO;

  logic [2*LO-1:0]  ll_q;
  logic [LO+HI-1:0] lh_q, hl_q;
  logic [2*HI-1:0]  hh_q;
  logic [2*W-1:0]   p_q;

  always_ff @(posedge clk_i) begin
    ll_q <= (2*LO)'(a_i[LO-1:0]) * (2*LO)'(b_i[LO-1:0]);
    lh_q <= (LO+HI)'(a_i[LO-1:0]) * (LO+HI)'(b_i[W-1:LO]);
    hl_q <= (LO+HI)'(a_i[W-1:LO]) * (LO+HI)'(b_i[LO-1:0]);
    hh_q <= (2*HI)'(a_i[W-1:LO]) * (2*HI)'(b_i[W-1:LO]);
    p_q  <= (2*W)'(ll_q) + (((2*W)'(lh_q) + (2*W)'(hl_q)) << LO)
          + ((2*W)'(hh_q) << (2*LO));
  end

  assign p_o = p_q;

endmodule

/* design/sat_geom.sv */
// Pair geometry: separating-axis and distance tests, eight stages.
module sat_geom #(
  parameter int CW = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  logic [1:0]                               kind_a_i,
  input  logic signed [CW-1:0]                     x_a_i,
  input  logic signed [CW-1:0]                     y_a_i,
  input  logic [CW-2:0]                            w_a_i,
  input  logic [CW-2:0]                            h_a_i,
  input  logic signed [sat_pkg::trig_frac(CW)+1:0] ux_a_i,
  input  logic signed [sat_pkg::trig_frac(CW)+1:0] uy_a_i,
  input  logic [1:0]                               kind_b_i,
  input  logic signed [CW-1:0]                     x_b_i,
  input  logic signed [CW-1:0]                     y_b_i,
  input  logic [CW-2:0]                            w_b_i,
  input  logic [CW-2:0]                            h_b_i,
  input  logic signed [sat_pkg::trig_frac(CW)+1:0] ux_b_i,
  input  logic signed [sat_pkg::trig_frac(CW)+1:0] uy_b_i,
  output logic                                     strobe_o,
  output logic                                     colliding_o
);

  localparam int F   = sat_pkg::trig_frac(CW);
  localparam int UW  = F + 2;
  localparam int DW  = CW + 1;
  localparam int PW  = UW + DW;
  localparam int NW  = PW + 1;
  localparam int MW  = NW;
  localparam int DPW = 2 * UW;
  localparam int DSW = DPW + 1;
  localparam int ADW = F + 3;
  localparam int EXW = ADW + CW - 1;
  localparam int ETW = EXW + 2;
  localparam int SQW = MW;

  typedef struct packed {
    sat_pkg::pair_e pt;
    logic           swap;
    logic [CW-2:0]  wa, ha, wb, hb, rc;
    logic [CW-1:0]  rs;
  } side_t;

  logic [sat_pkg::GEOM_LAT-1:0] vld_q;

  // G1 decode
  logic                a_c, a_r, b_c, b_r;
  side_t               side_d, side1_q, side2_q, side3_q;
  logic signed [DW-1:0] dx_d, dy_d, dx1_q, dy1_q;
  logic signed [UW-1:0] vx1_q [4];
  logic signed [UW-1:0] vy1_q [4];

  always_comb begin
    a_c = kind_a_i == sat_pkg::KIND_CIRCLE;
    a_r = kind_a_i == sat_pkg::KIND_RECT;
    b_c = kind_b_i == sat_pkg::KIND_CIRCLE;
    b_r = kind_b_i == sat_pkg::KIND_RECT;
    if (a_c && b_c)                        side_d.pt = sat_pkg::PAIR_CC;
    else if (a_r && b_r)                   side_d.pt = sat_pkg::PAIR_RR;
    else if ((a_r && b_c) || (a_c && b_r)) side_d.pt = sat_pkg::PAIR_RC;
    else                                   side_d.pt = sat_pkg::PAIR_NONE;
    // circle first: measure from the rectangle b
    side_d.swap = a_c && b_r;
    side_d.wa   = w_a_i;
    side_d.ha   = h_a_i;
    side_d.wb   = w_b_i;
    side_d.hb   = h_b_i;
    side_d.rc   = side_d.swap ? w_a_i : w_b_i;
    side_d.rs   = CW'(w_a_i) + CW'(w_b_i);
    dx_d = side_d.swap ? DW'(x_a_i) - DW'(x_b_i) : DW'(x_b_i) - DW'(x_a_i);
    dy_d = side_d.swap ? DW'(y_a_i) - DW'(y_b_i) : DW'(y_b_i) - DW'(y_a_i);
  end

  always_ff @(posedge clk_i) begin
    side1_q  <= side_d;
    dx1_q    <= dx_d;
    dy1_q    <= dy_d;
    // axes: u_a, v_a, u_b, v_b with v = (-uy, ux)
    vx1_q[0] <= ux_a_i;
    vy1_q[0] <= uy_a_i;
    vx1_q[1] <= -uy_a_i;
    vy1_q[1] <= ux_a_i;
    vx1_q[2] <= ux_b_i;
    vy1_q[2] <= uy_b_i;
    vx1_q[3] <= -uy_b_i;
    vy1_q[3] <= ux_b_i;
  end

  // G2 products
  logic [DW-1:0]         adx2_q, ady2_q, adx3_q, ady3_q;
  logic signed [PW-1:0]  pnx2_q [4];
  logic signed [PW-1:0]  pny2_q [4];
  logic signed [DPW-1:0] ppx2_q [4][4];
  logic signed [DPW-1:0] ppy2_q [4][4];

  always_ff @(posedge clk_i) begin
    side2_q <= side1_q;
    adx2_q  <= dx1_q[DW-1] ? DW'(-dx1_q) : DW'(dx1_q);
    ady2_q  <= dy1_q[DW-1] ? DW'(-dy1_q) : DW'(dy1_q);
    for (int k = 0; k < 4; k++) begin
      pnx2_q[k] <= PW'(vx1_q[k]) * PW'(dx1_q);
      pny2_q[k] <= PW'(vy1_q[k]) * PW'(dy1_q);
      for (int j = 0; j < 4; j++) begin
        ppx2_q[k][j] <= DPW'(vx1_q[k]) * DPW'(vx1_q[j]);
        ppy2_q[k][j] <= DPW'(vy1_q[k]) * DPW'(vy1_q[j]);
      end
    end
  end

  // G3 projections
  logic signed [NW-1:0]  nd [4];
  logic signed [DSW-1:0] ds [4][4];
  logic [DSW-1:0]        dmag [4][4];
  logic [MW-1:0]         mag3_q [4];
  logic [ADW-1:0]        adot3_q [4][4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nd[k] = NW'(pnx2_q[k]) + NW'(pny2_q[k]);
      for (int j = 0; j < 4; j++) begin
        ds[k][j]   = DSW'(ppx2_q[k][j]) + DSW'(ppy2_q[k][j]);
        dmag[k][j] = ds[k][j][DSW-1] ? DSW'(-ds[k][j]) : DSW'(ds[k][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side2_q;
    adx3_q  <= adx2_q;
    ady3_q  <= ady2_q;
    for (int k = 0; k < 4; k++) begin
      mag3_q[k] <= (nd[k][NW-1] ? MW'(-nd[k]) : MW'(nd[k])) << 1;
      for (int j = 0; j < 4; j++)
        adot3_q[k][j] <= ADW'((dmag[k][j] + (DSW'(1) << (F - 1))) >> F);
    end
  end

  // G4 extents, circle distances, square operands
  logic [CW-2:0]   dim [4];
  logic [CW-2:0]   rw, rh;
  logic [MW-1:0]   mx, my, wf, hf, rf2, ex, ey;
  logic            fail_d;
  logic [SQW-1:0]  op_d [3];
  logic [SQW-1:0]  op4_q [3];
  logic [EXW-1:0]  ext4_q [4][4];
  logic [MW-1:0]   mag4_q [4];
  logic [3:0]      skip4_q;
  logic            fail4_q;
  sat_pkg::pair_e  pt4_q;

  always_comb begin
    dim[0] = side3_q.wa;
    dim[1] = side3_q.ha;
    dim[2] = side3_q.wb;
    dim[3] = side3_q.hb;
    rw     = side3_q.swap ? side3_q.wb : side3_q.wa;
    rh     = side3_q.swap ? side3_q.hb : side3_q.ha;
    mx     = side3_q.swap ? mag3_q[2] : mag3_q[0];
    my     = side3_q.swap ? mag3_q[3] : mag3_q[1];
    wf     = MW'(rw) << F;
    hf     = MW'(rh) << F;
    rf2    = MW'(side3_q.rc) << (F + 1);
    fail_d = ((rw != '0) && (mx > wf + rf2)) || ((rh != '0) && (my > hf + rf2));
    ex     = (mx > wf) ? mx - wf : '0;
    ey     = (my > hf) ? my - hf : '0;
    case (side3_q.pt)
      sat_pkg::PAIR_CC: begin
        op_d[0] = SQW'(adx3_q);
        op_d[1] = SQW'(ady3_q);
        op_d[2] = SQW'(side3_q.rs);
      end
      sat_pkg::PAIR_RC: begin
        op_d[0] = SQW'(ex);
        op_d[1] = SQW'(ey);
        op_d[2] = SQW'(rf2);
      end
      default: begin
        op_d[0] = '0;
        op_d[1] = '0;
        op_d[2] = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      mag4_q[k] <= mag3_q[k];
      for (int j = 0; j < 4; j++)
        ext4_q[k][j] <= EXW'(adot3_q[k][j]) * EXW'(dim[j]);
    end
    for (int i = 0; i < 3; i++) op4_q[i] <= op_d[i];
    skip4_q <= {side3_q.hb == '0, side3_q.wb == '0, side3_q.ha == '0, side3_q.wa == '0};
    fail4_q <= fail_d;
    pt4_q   <= side3_q.pt;
  end

  // G5/G6 squares
  logic [2*SQW-1:0] sq [3];

  for (genvar i = 0; i < 3; i++) begin : g_sq
    sat_mul #(.W(SQW)) u_sq (
      .clk_i (clk_i),
      .a_i   (op4_q[i]),
      .b_i   (op4_q[i]),
      .p_o   (sq[i])
    );
  end

  logic [ETW-1:0] esa5_q [4];
  logic [ETW-1:0] esb5_q [4];
  logic [MW-1:0]  mag5_q [4];
  logic [3:0]     skip5_q, ok6_q;
  logic           fail5_q, fail6_q, fail7_q;
  sat_pkg::pair_e pt5_q, pt6_q, pt7_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      esa5_q[k] <= ETW'(ext4_q[k][0]) + ETW'(ext4_q[k][1]);
      esb5_q[k] <= ETW'(ext4_q[k][2]) + ETW'(ext4_q[k][3]);
      mag5_q[k] <= mag4_q[k];
      ok6_q[k]  <= skip5_q[k] || (mag5_q[k] <= esa5_q[k] + esb5_q[k]);
    end
    skip5_q <= skip4_q;
    fail5_q <= fail4_q;
    fail6_q <= fail5_q;
    pt5_q   <= pt4_q;
    pt6_q   <= pt5_q;
  end

  // G7 sum of squares, G8 verdict
  logic [2*SQW:0]   ss7_q;
  logic [2*SQW-1:0] lim7_q;
  logic             rr7_q;
  logic             col_d, col_q;

  always_ff @(posedge clk_i) begin
    ss7_q   <= (2*SQW+1)'(sq[0]) + (2*SQW+1)'(sq[1]);
    lim7_q  <= sq[2];
    rr7_q   <= &ok6_q;
    fail7_q <= fail6_q;
    pt7_q   <= pt6_q;
  end

  always_comb begin
    case (pt7_q)
      sat_pkg::PAIR_CC: col_d = ss7_q <= (2*SQW+1)'(lim7_q);
      sat_pkg::PAIR_RR: col_d = rr7_q;
      sat_pkg::PAIR_RC: col_d = !fail7_q && (ss7_q <= (2*SQW+1)'(lim7_q));
      default:          col_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[sat_pkg::GEOM_LAT-2:0], valid_i};
    end
  end

  assign strobe_o    = vld_q[sat_pkg::GEOM_LAT-1];
  assign colliding_o = col_q;

endmodule

/* design/sat_shape_overlap_test_core.sv */
// Shape pair overlap test: each item goes through a register pipeline
// (1 input register, 24 in the sine/cosine series pipeline, 8 in the pair geometry);
// strobe is high for a single cycle with each result.
// Throughput one item per clock; busy stays low and results cannot be stalled.
// Reset clears only the valid bits; the datapath carries no state between items.
`include "sat_shape_overlap_test_core_macros.svh"

module sat_shape_overlap_test_core #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_a_i,
  input  logic signed [COORD_WIDTH-1:0] a_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_y_i,
  input  logic [ANGLE_WIDTH-1:0]        a_angle_i,
  input  logic [COORD_WIDTH-2:0]        a_extent_x_i,
  input  logic [COORD_WIDTH-2:0]        a_extent_y_i,
  input  logic [1:0]                    kind_b_i,
  input  logic signed [COORD_WIDTH-1:0] b_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_y_i,
  input  logic [ANGLE_WIDTH-1:0]        b_angle_i,
  input  logic [COORD_WIDTH-2:0]        b_extent_x_i,
  input  logic [COORD_WIDTH-2:0]        b_extent_y_i,
  output logic                          strobe_o,
  output logic                          colliding_o
);

  localparam int F         = sat_pkg::trig_frac(COORD_WIDTH);
  localparam int TL        = sat_pkg::TRIG_LAT;
  localparam int TOTAL_LAT = 1 + sat_pkg::TRIG_LAT + sat_pkg::GEOM_LAT;

  // Shape fields that bypass the trig pipeline.
  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-2:0]        w;
    logic [COORD_WIDTH-2:0]        h;
  } shape_t;

  // Fully pipelined: a new item is taken every cycle.
  assign busy = 1'b0;

  // Input register.
  logic                   v0_q;
  shape_t                 a0_q, b0_q;
  logic [ANGLE_WIDTH-1:0] ang_a0_q, ang_b0_q;

  always_ff @(posedge clk_i) begin
    a0_q     <= '{kind_a_i, a_x_i, a_y_i, a_extent_x_i, a_extent_y_i};
    b0_q     <= '{kind_b_i, b_x_i, b_y_i, b_extent_x_i, b_extent_y_i};
    ang_a0_q <= a_angle_i;
    ang_b0_q <= b_angle_i;
  end

  // Unit width axis of each shape; the height axis is derived from it later.
  logic signed [F+1:0] ux_a, uy_a, ux_b, uy_b;

  sat_trig #(.CW(COORD_WIDTH), .AW(ANGLE_WIDTH)) u_trig_a (
    .clk_i   (clk_i),
    .angle_i (ang_a0_q),
    .ux_o    (ux_a),
    .uy_o    (uy_a)
  );

  sat_trig #(.CW(COORD_WIDTH), .AW(ANGLE_WIDTH)) u_trig_b (
    .clk_i   (clk_i),
    .angle_i (ang_b0_q),
    .ux_o    (ux_b),
    .uy_o    (uy_b)
  );

  // Delay line that keeps the other fields aligned with the trig results.
  shape_t    dly_a_q [TL];
  shape_t    dly_b_q [TL];
  logic [TL-1:0] dly_v_q;

  always_ff @(posedge clk_i) begin
    dly_a_q[0] <= a0_q;
    dly_b_q[0] <= b0_q;
    for (int i = 1; i < TL; i++) begin
      dly_a_q[i] <= dly_a_q[i-1];
      dly_b_q[i] <= dly_b_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      dly_v_q <= '0;
    end else begin
      v0_q    <= start;
      dly_v_q <= {dly_v_q[TL-2:0], v0_q};
    end
  end

  // Pair tests: circle/circle distance, rect/rect on four axes,
  // rect/circle on two axes plus the closest-point axis.
  sat_geom #(.CW(COORD_WIDTH)) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dly_v_q[TL-1]),
    .kind_a_i    (dly_a_q[TL-1].kind),
    .x_a_i       (dly_a_q[TL-1].x),
    .y_a_i       (dly_a_q[TL-1].y),
    .w_a_i       (dly_a_q[TL-1].w),
    .h_a_i       (dly_a_q[TL-1].h),
    .ux_a_i      (ux_a),
    .uy_a_i      (uy_a),
    .kind_b_i    (dly_b_q[TL-1].kind),
    .x_b_i       (dly_b_q[TL-1].x),
    .y_b_i       (dly_b_q[TL-1].y),
    .w_b_i       (dly_b_q[TL-1].w),
    .h_b_i       (dly_b_q[TL-1].h),
    .ux_b_i      (ux_b),
    .uy_b_i      (uy_b),
    .strobe_o    (strobe_o),
    .colliding_o (colliding_o)
  );

  // An absent or unused kind on either side can never report a hit.
  logic pair_absent;
  assign pair_absent =
    ((kind_a_i != sat_pkg::KIND_CIRCLE) && (kind_a_i != sat_pkg::KIND_RECT)) ||
    ((kind_b_i != sat_pkg::KIND_CIRCLE) && (kind_b_i != sat_pkg::KIND_RECT));

  `SAT_ASSERT(a_lat_fwd, start |-> ##TOTAL_LAT strobe_o)
  `SAT_ASSERT(a_lat_back, strobe_o |-> $past(start, TOTAL_LAT))
  `SAT_ASSERT_NEVER(a_absent_hit, strobe_o && colliding_o && $past(pair_absent, TOTAL_LAT))

endmodule

/* tb/sv/sat_shape_overlap_checker.sv */
`timescale 1ns / 100ps

// Watches the command and result ports of the overlap core, predicts the
// collide flag of every accepted item and compares it with each strobe.
module sat_shape_overlap_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         kind_a_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic [15:0]        a_angle_i,
  input  logic [30:0]        a_extent_x_i,
  input  logic [30:0]        a_extent_y_i,
  input  logic [1:0]         kind_b_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic [15:0]        b_angle_i,
  input  logic [30:0]        b_extent_x_i,
  input  logic [30:0]        b_extent_y_i,
  input  logic               strobe_o,
  input  logic               colliding_o,
  output int                 fail_count,
  output int                 pending,
  output int                 hit_count,
  output int                 result_count
);

  localparam int                FRAC    = 28;
  localparam longint unsigned   ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned   HALF_PI = 64'd1686629713;

  typedef struct {
    logic [1:0]      kind;
    longint          x, y, ux, uy;
    longint unsigned w, h;
  } shape_t;

  bit collide_q[$];

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? (64'd0 - longint'(v)) : v;
  endfunction

  function automatic longint unsigned den_k(input int i, input bit is_sin);
    if (is_sin) begin
      case (i)
        0: return 6;   1: return 20;  2: return 42;
        3: return 72;  4: return 110; default: return 156;
      endcase
    end
    case (i)
      0: return 2;   1: return 12;  2: return 30;  3: return 56;
      4: return 90;  5: return 132; default: return 182;
    endcase
  endfunction

  function automatic longint unsigned taylor(input longint unsigned x2, input bit is_sin);
    longint unsigned t, p;
    t = ONE_Q30;
    for (int i = (is_sin ? 5 : 6); i >= 0; i--) begin
      p = ((x2 * t) >> 30) / den_k(i, is_sin);
      t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
    end
    return t;
  endfunction

  function automatic void unit_vec(input logic [15:0] ang, output longint cx,
                                   output longint sy);
    longint unsigned q, x, x2, s, c;
    longint sn, cs;
    q  = longint'(ang[13:0]) << 16;
    x  = (q * HALF_PI) >> 30;
    x2 = (x * x) >> 30;
    s  = (x * taylor(x2, 1'b1)) >> 30;
    c  = taylor(x2, 1'b0);
    if (s > ONE_Q30) s = ONE_Q30;
    sn = (s + 2) >> 2;
    cs = (c + 2) >> 2;
    case (ang[15:14])
      2'd0: begin cx = cs;  sy = sn;  end
      2'd1: begin cx = -sn; sy = cs;  end
      2'd2: begin cx = -cs; sy = -sn; end
      default: begin cx = sn; sy = -cs; end
    endcase
  endfunction

  function automatic longint unsigned proj(input longint ax, ay, bx, by);
    longint unsigned m;
    m = mag(ax * bx + ay * by);
    return (m + (64'd1 << (FRAC - 1))) >> FRAC;
  endfunction

  function automatic longint unsigned half_ext2(input shape_t r, input longint nx, ny);
    return proj(nx, ny, r.ux, r.uy) * r.w + proj(nx, ny, -r.uy, r.ux) * r.h;
  endfunction

  function automatic bit axis_overlap(input shape_t a, b, input longint nx, ny);
    longint dx, dy;
    longint unsigned sep2;
    dx   = b.x - a.x;
    dy   = b.y - a.y;
    sep2 = 64'd2 * mag(nx * dx + ny * dy);
    return sep2 <= half_ext2(a, nx, ny) + half_ext2(b, nx, ny);
  endfunction

  function automatic bit rect_pair(input shape_t a, b);
    if (a.w != 0 && !axis_overlap(a, b, a.ux, a.uy)) return 1'b0;
    if (a.h != 0 && !axis_overlap(a, b, -a.uy, a.ux)) return 1'b0;
    if (b.w != 0 && !axis_overlap(a, b, b.ux, b.uy)) return 1'b0;
    if (b.h != 0 && !axis_overlap(a, b, -b.uy, b.ux)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint clip(input longint v, lim);
    return (v > lim) ? lim : ((v < -lim) ? -lim : v);
  endfunction

  function automatic bit rect_disc(input shape_t r, c);
    longint dx, dy, lx2, ly2, wf, hf;
    longint unsigned rf2, ex, ey;
    bit [127:0] lhs, rhs;
    dx  = c.x - r.x;
    dy  = c.y - r.y;
    lx2 = 2 * (r.ux * dx + r.uy * dy);
    ly2 = 2 * (-r.uy * dx + r.ux * dy);
    wf  = longint'(r.w << FRAC);
    hf  = longint'(r.h << FRAC);
    rf2 = c.w << (FRAC + 1);
    if (r.w != 0 && mag(lx2) > longint'(wf) + rf2) return 1'b0;
    if (r.h != 0 && mag(ly2) > longint'(hf) + rf2) return 1'b0;
    ex  = mag(clip(lx2, wf) - lx2);
    ey  = mag(clip(ly2, hf) - ly2);
    lhs = {64'd0, ex} * {64'd0, ex} + {64'd0, ey} * {64'd0, ey};
    rhs = {64'd0, rf2} * {64'd0, rf2};
    return lhs <= rhs;
  endfunction

  function automatic bit disc_pair(input shape_t a, b);
    longint unsigned dx, dy, rs;
    bit [127:0] lhs, rhs;
    dx  = mag(b.x - a.x);
    dy  = mag(b.y - a.y);
    rs  = a.w + b.w;
    lhs = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy};
    rhs = {64'd0, rs} * {64'd0, rs};
    return lhs <= rhs;
  endfunction

  function automatic bit predict_collide(input shape_t a, b);
    if (a.kind == sat_pkg::KIND_CIRCLE && b.kind == sat_pkg::KIND_CIRCLE)
      return disc_pair(a, b);
    if (a.kind == sat_pkg::KIND_RECT && b.kind == sat_pkg::KIND_RECT)
      return rect_pair(a, b);
    if (a.kind == sat_pkg::KIND_RECT && b.kind == sat_pkg::KIND_CIRCLE)
      return rect_disc(a, b);
    if (a.kind == sat_pkg::KIND_CIRCLE && b.kind == sat_pkg::KIND_RECT)
      return rect_disc(b, a);
    return 1'b0;
  endfunction

  assign pending = collide_q.size();

  always @(posedge clk_i) begin
    shape_t sa, sb;
    bit want;
    if (!rst_ni) begin
      fail_count   = 0;
      hit_count    = 0;
      result_count = 0;
    end else begin
      if (start && !busy) begin
        sa.kind = kind_a_i;  sa.x = a_x_i;  sa.y = a_y_i;
        sa.w = a_extent_x_i; sa.h = a_extent_y_i;
        unit_vec(a_angle_i, sa.ux, sa.uy);
        sb.kind = kind_b_i;  sb.x = b_x_i;  sb.y = b_y_i;
        sb.w = b_extent_x_i; sb.h = b_extent_y_i;
        unit_vec(b_angle_i, sb.ux, sb.uy);
        collide_q = {collide_q, predict_collide(sa, sb)};
      end
      if (strobe_o) begin
        result_count++;
        if (colliding_o === 1'b1) hit_count++;
        if (collide_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no item waiting: expected none, actual colliding=%b",
                   $time, colliding_o);
        end else begin
          want = collide_q.pop_front();
          if (colliding_o !== want) begin
            fail_count++;
            $display("%0t: colliding mismatch: expected %b, actual %b",
                     $time, want, colliding_o);
          end
        end
      end
    end
  end

endmodule

/* tb/sv/sat_shape_overlap_test_core_tb.sv */
`timescale 1ns / 100ps

// Top of the overlap core bench: clock, reset, command stimulus and verdict.
// Checking lives in the checker instance beside the DUT.
module sat_shape_overlap_test_core_tb;

  localparam int RUN_LIMIT = 200000;  // cycles
  localparam int DRAIN     = 40;      // longer than the core latency

  logic               clk_i, rst_ni, start, busy, strobe_o, colliding_o;
  logic [1:0]         kind_a_i, kind_b_i;
  logic signed [31:0] a_x_i, a_y_i, b_x_i, b_y_i;
  logic [15:0]        a_angle_i, b_angle_i;
  logic [30:0]        a_extent_x_i, a_extent_y_i, b_extent_x_i, b_extent_y_i;

  int fail_count, pending, hit_count, result_count;
  int cycles = 0;
  int item_count;

  sat_shape_overlap_test_core DUT (.*);
  sat_shape_overlap_checker chk (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: the whole run, drain included, must end before the watchdog fires
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still waiting", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one item and hold it until the core takes it. start stays high
  // after acceptance so back-to-back items keep it asserted.
  task automatic send_pair(input logic [1:0] ka, input logic [31:0] ax, ay,
                           input logic [31:0] aang, aw, ah,
                           input logic [1:0] kb, input logic [31:0] bx, by,
                           input logic [31:0] bang, bw, bh);
    kind_a_i <= ka;  a_x_i <= ax;  a_y_i <= ay;  a_angle_i <= aang[15:0];
    a_extent_x_i <= aw[30:0];  a_extent_y_i <= ah[30:0];
    kind_b_i <= kb;  b_x_i <= bx;  b_y_i <= by;  b_angle_i <= bang[15:0];
    b_extent_x_i <= bw[30:0];  b_extent_y_i <= bh[30:0];
    start <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    item_count++;
  endtask

  // Sender gap: each cycle idles with the given odds in percent.
  task automatic maybe_idle(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(19);
    if (r == 0) return sat_pkg::KIND_NONE;
    if (r == 1) return sat_pkg::KIND_UNUSED;   // reads as absent
    return (r[0]) ? sat_pkg::KIND_CIRCLE : sat_pkg::KIND_RECT;
  endfunction

  // Near coordinate: within about +-16 units of the origin, so pairs touch often.
  function automatic logic [31:0] near_coord();
    return $urandom_range(0, 2097151) - 1048576;
  endfunction

  function automatic logic [31:0] near_ext();
    if ($urandom_range(15) == 0) return '0;   // degenerate edge
    return 32'($urandom_range(1, 1 << 20));
  endfunction

  function automatic logic [31:0] pick_angle();
    if ($urandom_range(7) == 0) return 32'($urandom_range(3)) << 14;
    return $urandom;
  endfunction

  task automatic random_item();
    logic [31:0] ax, ay, bx, by;
    logic [31:0] aw, ah, bw, bh;
    if ($urandom_range(4) == 0) begin
      // full range: every bit of every field toggles
      ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
      aw = $urandom; ah = $urandom; bw = $urandom; bh = $urandom;
    end else begin
      ax = near_coord(); ay = near_coord(); bx = near_coord(); by = near_coord();
      aw = near_ext(); ah = near_ext(); bw = near_ext(); bh = near_ext();
    end
    send_pair(pick_kind(), ax, ay, pick_angle(), aw, ah,
              pick_kind(), bx, by, pick_angle(), bw, bh);
  endtask

  localparam logic [31:0] U = 32'h0001_0000;  // one unit in Q16.16

  initial begin
    int pct;
    item_count = 0;
    rst_ni = 1'b0;
    start <= 1'b0;
    kind_a_i <= sat_pkg::KIND_NONE;  a_x_i <= '0;  a_y_i <= '0;  a_angle_i <= '0;
    a_extent_x_i <= '0;  a_extent_y_i <= '0;
    kind_b_i <= sat_pkg::KIND_NONE;  b_x_i <= '0;  b_y_i <= '0;  b_angle_i <= '0;
    b_extent_x_i <= '0;  b_extent_y_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed items ----
    // absent shape on either side, and the unused kind code
    send_pair(sat_pkg::KIND_NONE, 0, 0, 0, U, U, sat_pkg::KIND_CIRCLE, 0, 0, 0, U, U);
    send_pair(sat_pkg::KIND_CIRCLE, 0, 0, 0, U, U, sat_pkg::KIND_NONE, 0, 0, 0, U, U);
    send_pair(sat_pkg::KIND_UNUSED, 0, 0, 0, U, U, sat_pkg::KIND_RECT, 0, 0, 0, U, U);
    // circles touching exactly (3-4-5), then just apart
    send_pair(sat_pkg::KIND_CIRCLE, 0, 0, 0, 2*U, 0,
              sat_pkg::KIND_CIRCLE, 3*U, 4*U, 0, 3*U, 0);
    send_pair(sat_pkg::KIND_CIRCLE, 0, 0, 0, 2*U, 0,
              sat_pkg::KIND_CIRCLE, 3*U, 4*U + 1, 0, 3*U, 0);
    // rectangles: aligned, edge-to-edge, rotated by an eighth turn, quadrant angles
    send_pair(sat_pkg::KIND_RECT, 0, 0, 0, 2*U, 2*U, sat_pkg::KIND_RECT, U, U, 0, 2*U, 2*U);
    send_pair(sat_pkg::KIND_RECT, 0, 0, 0, 2*U, 2*U,
              sat_pkg::KIND_RECT, 2*U, 0, 0, 2*U, 2*U);
    send_pair(sat_pkg::KIND_RECT, 0, 0, 16'h2000, 2*U, 2*U,
              sat_pkg::KIND_RECT, 3*U, 0, 0, 2*U, 2*U);
    send_pair(sat_pkg::KIND_RECT, 0, 0, 16'h4000, 4*U, U,
              sat_pkg::KIND_RECT, 0, 2*U, 16'h8000, U, U);
    send_pair(sat_pkg::KIND_RECT, 0, 0, 16'hC000, 4*U, U,
              sat_pkg::KIND_RECT, 0, 3*U, 16'hFFFF, U, U);
    // zero width and zero height rectangles
    send_pair(sat_pkg::KIND_RECT, 0, 0, 0, 0, 2*U, sat_pkg::KIND_RECT, 5*U, 0, 0, 2*U, 2*U);
    send_pair(sat_pkg::KIND_RECT, 0, 0, 0, 2*U, 0, sat_pkg::KIND_RECT, 0, 5*U, 0, 2*U, 2*U);
    send_pair(sat_pkg::KIND_RECT, 0, 0, 0, 0, 0, sat_pkg::KIND_RECT, 0, 0, 0, 0, 0);
    // circle centre inside the rectangle, both orders; corner region miss
    send_pair(sat_pkg::KIND_RECT, 0, 0, 0, 4*U, 4*U, sat_pkg::KIND_CIRCLE, U, U, 0, U, 0);
    send_pair(sat_pkg::KIND_CIRCLE, U, U, 0, U, 0, sat_pkg::KIND_RECT, 0, 0, 0, 4*U, 4*U);
    send_pair(sat_pkg::KIND_RECT, 0, 0, 0, 2*U, 2*U,
              sat_pkg::KIND_CIRCLE, 2*U, 2*U, 0, U, 0);
    send_pair(sat_pkg::KIND_CIRCLE, 2*U, 2*U, 16'h1234, U, 0,
              sat_pkg::KIND_RECT, 0, 0, 16'h2000, 2*U, 2*U);
    // field extremes
    send_pair(sat_pkg::KIND_CIRCLE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, '1, '1,
              sat_pkg::KIND_CIRCLE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, '1, '1);
    send_pair(sat_pkg::KIND_RECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, '1, '1,
              sat_pkg::KIND_RECT, 32'h8000_0000, 32'h8000_0000, 16'h0000, '1, '1);
    send_pair(sat_pkg::KIND_RECT, 32'h8000_0000, 32'h7FFF_FFFF, 16'h3FFF, '1, 0,
              sat_pkg::KIND_CIRCLE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, '1, '1);
    send_pair(sat_pkg::KIND_CIRCLE, 0, 0, 0, 0, 0, sat_pkg::KIND_CIRCLE, 0, 0, 0, 0, 0);

    // ---- random items: sender idles 6%, then 61%, then not at all ----
    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 6 : ((ph == 1) ? 61 : 0);
      repeat (250) begin
        maybe_idle(pct);
        random_item();
      end
    end
    start <= 1'b0;

    // drain: wait for every predicted flag, then wait out DRAIN
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Sent %0d shape pairs (absent, circle and rectangle mixes, extremes);",
             item_count);
    $display("checked %0d collide flags, %0d of them set.", result_count, hit_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
